// ----- src/assert_macros.svh -----
// shared assertion macros for the linked queue block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check, off while reset is held
`define LQFL_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// same-cycle implication check, off while reset is held
`define LQFL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- src/lqfl_pkg.sv -----
package lqfl_pkg;

    // request codes
    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    // result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_ENQ_RD,
        S_ENQ_LINK,
        S_ENQ_TAIL,
        S_DEQ_RD,
        S_DEQ_LINK,
        S_DEQ_FRONT,
        S_PUSH
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic dispatch;
        logic enq_rd;
        logic enq_link;
        logic enq_tail;
        logic deq_rd;
        logic deq_link;
        logic deq_front;
        logic push;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic req_deq;
        logic free_valid;
        logic head_valid;
        logic link_valid;
        logic out_free;
    } t_sts;

endpackage

// ----- src/lqfl_ram.sv -----
module lqfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // one write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- src/lqfl_ctrl.sv -----
`include "assert_macros.svh"

module lqfl_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  lqfl_pkg::t_sts i_sts,
    output lqfl_pkg::t_cmd o_cmd
);

    lqfl_pkg::t_state r_state;
    lqfl_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lqfl_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lqfl_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = lqfl_pkg::S_DISPATCH;
                end
            end
            lqfl_pkg::S_DISPATCH: begin
                if (i_sts.req_deq) begin
                    n_state = i_sts.head_valid ? lqfl_pkg::S_DEQ_RD : lqfl_pkg::S_PUSH;
                end else begin
                    n_state = i_sts.free_valid ? lqfl_pkg::S_ENQ_RD : lqfl_pkg::S_PUSH;
                end
            end
            lqfl_pkg::S_ENQ_RD:    n_state = lqfl_pkg::S_ENQ_LINK;
            lqfl_pkg::S_ENQ_LINK:  n_state = lqfl_pkg::S_ENQ_TAIL;
            lqfl_pkg::S_ENQ_TAIL:  n_state = lqfl_pkg::S_PUSH;
            lqfl_pkg::S_DEQ_RD:    n_state = lqfl_pkg::S_DEQ_LINK;
            lqfl_pkg::S_DEQ_LINK: begin
                n_state = i_sts.link_valid ? lqfl_pkg::S_DEQ_FRONT : lqfl_pkg::S_PUSH;
            end
            lqfl_pkg::S_DEQ_FRONT: n_state = lqfl_pkg::S_PUSH;
            lqfl_pkg::S_PUSH: begin
                if (i_sts.out_free) begin
                    n_state = lqfl_pkg::S_IDLE;
                end
            end
            default: n_state = lqfl_pkg::S_IDLE;
        endcase
    end

    // command decode, no input beat taken while reset is held
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            lqfl_pkg::S_IDLE: begin
                o_in_ready = i_rst_n;
                o_cmd.load = i_in_valid && i_rst_n;
            end
            lqfl_pkg::S_DISPATCH:  o_cmd.dispatch  = 1'b1;
            lqfl_pkg::S_ENQ_RD:    o_cmd.enq_rd    = 1'b1;
            lqfl_pkg::S_ENQ_LINK:  o_cmd.enq_link  = 1'b1;
            lqfl_pkg::S_ENQ_TAIL:  o_cmd.enq_tail  = 1'b1;
            lqfl_pkg::S_DEQ_RD:    o_cmd.deq_rd    = 1'b1;
            lqfl_pkg::S_DEQ_LINK:  o_cmd.deq_link  = 1'b1;
            lqfl_pkg::S_DEQ_FRONT: o_cmd.deq_front = 1'b1;
            lqfl_pkg::S_PUSH:      o_cmd.push      = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

    // at most one list operation step per cycle
    `LQFL_ASSERT(a_one_step, i_clk, i_rst_n,
        $onehot0({o_cmd.dispatch, o_cmd.enq_rd, o_cmd.enq_link, o_cmd.enq_tail,
                  o_cmd.deq_rd, o_cmd.deq_link, o_cmd.deq_front, o_cmd.push}),
        "more than one sequencer step active")

endmodule

// ----- src/lqfl_datapath.sv -----
`include "assert_macros.svh"

module lqfl_datapath #(
    parameter int NODE_COUNT = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lqfl_pkg::t_cmd i_cmd,
    output lqfl_pkg::t_sts o_sts,
    input  logic           i_req_type,
    input  logic [7:0]     i_elem,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    output logic [1:0]     o_status,
    output logic [7:0]     o_out_byte,
    output logic           o_queue_empty,
    output logic [7:0]     o_front_byte,
    output logic [7:0]     o_rear_byte
);

    // node index, link = {valid, index}, fresh count holds 0..NODE_COUNT
    localparam int IW = $clog2(NODE_COUNT);
    localparam int LW = IW + 1;
    localparam int FW = $clog2(NODE_COUNT + 1);
    localparam logic [LW-1:0] NIL = '0;

    // list state
    logic [LW-1:0] r_free;
    logic [LW-1:0] r_head;
    logic [LW-1:0] r_tail;
    logic [FW-1:0] r_fresh;
    logic [7:0]    r_front_byte;
    logic [7:0]    r_rear_byte;
    logic          r_out_valid;

    // per-item working registers
    logic          r_req;
    logic [7:0]    r_elem;
    logic [IW-1:0] r_node;
    logic [1:0]    r_status;
    logic [7:0]    r_out_byte;

    // result registers
    logic [1:0]    r_o_status;
    logic [7:0]    r_o_out_byte;
    logic          r_o_queue_empty;
    logic [7:0]    r_o_front_byte;
    logic [7:0]    r_o_rear_byte;

    // memory ports
    logic          next_wr_en;
    logic [IW-1:0] next_wr_addr;
    logic [LW-1:0] next_wr_data;
    logic [IW-1:0] next_rd_addr;
    logic [LW-1:0] next_rd_data;
    logic          bytes_wr_en;
    logic [IW-1:0] bytes_wr_addr;
    logic [7:0]    bytes_wr_data;
    logic [IW-1:0] bytes_rd_addr;
    logic [7:0]    bytes_rd_data;

    logic          w_free_fresh;
    logic [LW-1:0] w_fresh_link;
    logic [LW-1:0] w_enq_link;
    logic          w_out_free;

    lqfl_ram #(.WIDTH(LW), .DEPTH(NODE_COUNT)) u_next_ram (
        .i_clk     (i_clk),
        .i_wr_en   (next_wr_en),
        .i_wr_addr (next_wr_addr),
        .i_wr_data (next_wr_data),
        .i_rd_addr (next_rd_addr),
        .o_rd_data (next_rd_data)
    );

    lqfl_ram #(.WIDTH(8), .DEPTH(NODE_COUNT)) u_bytes_ram (
        .i_clk     (i_clk),
        .i_wr_en   (bytes_wr_en),
        .i_wr_addr (bytes_wr_addr),
        .i_wr_data (bytes_wr_data),
        .i_rd_addr (bytes_rd_addr),
        .o_rd_data (bytes_rd_data)
    );

    // untouched nodes below the fresh count still link downward
    assign w_free_fresh = (FW'(r_free[IW-1:0]) < r_fresh);
    assign w_fresh_link = (r_free[IW-1:0] == '0) ? NIL
                                                 : {1'b1, r_free[IW-1:0] - IW'(1)};
    assign w_enq_link   = w_free_fresh ? w_fresh_link : next_rd_data;
    assign w_out_free   = !r_out_valid || i_out_ready;

    // status to controller
    always_comb begin
        o_sts.req_deq    = (r_req == lqfl_pkg::REQ_DEQ);
        o_sts.free_valid = r_free[IW];
        o_sts.head_valid = r_head[IW];
        o_sts.link_valid = next_rd_data[IW];
        o_sts.out_free   = w_out_free;
    end

    // memory port steering
    always_comb begin
        next_wr_en    = 1'b0;
        next_wr_addr  = r_free[IW-1:0];
        next_wr_data  = NIL;
        next_rd_addr  = r_free[IW-1:0];
        bytes_wr_en   = i_cmd.enq_rd;
        bytes_wr_addr = r_free[IW-1:0];
        bytes_wr_data = r_elem;
        bytes_rd_addr = next_rd_data[IW-1:0];
        if (i_cmd.enq_link) begin
            next_wr_en = 1'b1;
        end
        if (i_cmd.enq_tail && r_head[IW] && r_tail[IW]) begin
            next_wr_en   = 1'b1;
            next_wr_addr = r_tail[IW-1:0];
            next_wr_data = {1'b1, r_node};
        end
        if (i_cmd.deq_rd) begin
            next_rd_addr = r_head[IW-1:0];
        end
        if (i_cmd.deq_link) begin
            next_wr_en   = 1'b1;
            next_wr_addr = r_head[IW-1:0];
            next_wr_data = r_free;
        end
    end

    // list pointers, byte caches, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free       <= {1'b1, IW'(NODE_COUNT - 1)};
            r_head       <= NIL;
            r_tail       <= NIL;
            r_fresh      <= FW'(NODE_COUNT);
            r_front_byte <= '0;
            r_rear_byte  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.enq_link) begin
                r_free <= w_enq_link;
                if (w_free_fresh) begin
                    r_fresh <= r_fresh - FW'(1);
                end
            end
            if (i_cmd.enq_tail) begin
                if (!(r_head[IW] && r_tail[IW])) begin
                    r_head       <= {1'b1, r_node};
                    r_front_byte <= r_elem;
                end
                r_tail      <= {1'b1, r_node};
                r_rear_byte <= r_elem;
            end
            if (i_cmd.deq_link) begin
                r_free <= r_head;
                if (next_rd_data[IW]) begin
                    r_head <= next_rd_data;
                end else begin
                    r_head       <= NIL;
                    r_tail       <= NIL;
                    r_front_byte <= '0;
                    r_rear_byte  <= '0;
                end
            end
            if (i_cmd.deq_front) begin
                r_front_byte <= bytes_rd_data;
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item payload and result beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req  <= i_req_type;
            r_elem <= i_elem;
        end
        if (i_cmd.dispatch) begin
            r_out_byte <= '0;
            if (r_req == lqfl_pkg::REQ_DEQ) begin
                r_status <= r_head[IW] ? lqfl_pkg::ST_DONE : lqfl_pkg::ST_EMPTY;
            end else begin
                r_status <= r_free[IW] ? lqfl_pkg::ST_DONE : lqfl_pkg::ST_FULL;
            end
        end
        if (i_cmd.enq_link) begin
            r_node <= r_free[IW-1:0];
        end
        if (i_cmd.deq_rd) begin
            r_out_byte <= r_front_byte;
        end
        if (i_cmd.push) begin
            r_o_status      <= r_status;
            r_o_out_byte    <= r_out_byte;
            r_o_queue_empty <= !r_head[IW];
            r_o_front_byte  <= r_front_byte;
            r_o_rear_byte   <= r_rear_byte;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_o_status;
    assign o_out_byte    = r_o_out_byte;
    assign o_queue_empty = r_o_queue_empty;
    assign o_front_byte  = r_o_front_byte;
    assign o_rear_byte   = r_o_rear_byte;

    // head and tail are null together
    `LQFL_ASSERT(a_head_tail_pair, i_clk, i_rst_n, r_head[IW] == r_tail[IW],
        "head and tail disagree on empty")

    // fresh count never grows past the node count
    `LQFL_ASSERT(a_fresh_bound, i_clk, i_rst_n, r_fresh <= FW'(NODE_COUNT),
        "fresh node count out of range")

    // an empty queue reports zero front and rear bytes
    `LQFL_ASSERT_IMP(a_empty_zero, i_clk, i_rst_n, r_out_valid && r_o_queue_empty,
        r_o_front_byte == '0 && r_o_rear_byte == '0,
        "empty queue shows nonzero front or rear")

endmodule

// ----- src/linked_queue_with_free_list_core.sv -----
// byte fifo kept as a linked list over NODE_COUNT nodes with a free list
// steps: a beat is dispatched, then an enqueue stores the byte in a free node,
//   links it and updates the tail; a dequeue unlinks the head and reloads the front
//   byte unless the queue empties; a full or empty rejection goes straight to the result
// flow: one item in flight, next beat taken the cycle after the result is registered
// reset: synchronous active low, queue empty, all nodes free, no clearing pass
module linked_queue_with_free_list_core #(
    parameter int NODE_COUNT = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_req_type,
    input  logic [7:0] i_elem,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_status,
    output logic [7:0] o_out_byte,
    output logic       o_queue_empty,
    output logic [7:0] o_front_byte,
    output logic [7:0] o_rear_byte
);

    lqfl_pkg::t_cmd cmd;
    lqfl_pkg::t_sts sts;

    // sequencer
    lqfl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .o_in_ready (o_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // list state and node memories
    lqfl_datapath #(.NODE_COUNT(NODE_COUNT)) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_req_type    (i_req_type),
        .i_elem        (i_elem),
        .i_out_ready   (i_ready),
        .o_out_valid   (o_valid),
        .o_status      (o_status),
        .o_out_byte    (o_out_byte),
        .o_queue_empty (o_queue_empty),
        .o_front_byte  (o_front_byte),
        .o_rear_byte   (o_rear_byte)
    );

endmodule
